// ----- hdl/crcrx_pkg.sv -----
`timescale 1ns / 1ps

package crcrx_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 11;

  localparam logic [7:0]  HDR0 = 8'h24;  // '$'
  localparam logic [7:0]  HDR1 = 8'h44;  // 'D'
  localparam logic [7:0]  HDR2 = 8'h43;  // 'C'

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [15:0] TIMEOUT_RESET = 16'd400;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_CRC_ERR = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/crc16_framed_channel_receiver.sv -----
`timescale 1ns / 1ps

// Framed channel receiver. Input beats carry either a serial byte (tuser = 0)
// or one time tick (tuser = 1). Bytes are scanned for the "$DC" header, then
// NUM_CHANNELS channel bytes and a big-endian CRC-16/CCITT-FALSE over header
// and channel bytes are collected. A good frame puts out NUM_CHANNELS channel
// beats (kind 0, tlast on the final one) and restarts the link timer; a bad
// CRC puts out one kind 1 beat. A running timer that reaches timeout_ticks
// puts out one kind 2 beat and stops until the next good frame. Each input
// beat is processed straight into the output register, so one beat per
// cycle is taken while the output side keeps up. A good frame then holds
// the input while the remaining channel beats drain from the output
// register, one per cycle while the output side keeps up.
module crc16_framed_channel_receiver
  import crcrx_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config: timeout_ticks
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tuser,   // [0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] channel, [11:4] value, [15:12] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last
);

  localparam int unsigned POS_W      = $clog2(NUM_CHANNELS + 5);
  localparam int unsigned IDX_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [POS_W-1:0] POS_HUNT   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR1   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_HDR2   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_DATA   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(3 + NUM_CHANNELS);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(NUM_CHANNELS - 1);

  // control state
  logic [15:0]      timeout_ticks;
  logic [POS_W-1:0] pos;
  logic [15:0]      crc;
  logic [15:0]      tmo_count;
  logic             tmo_running;
  logic             out_valid;
  logic             burst_active;
  logic [IDX_W-1:0] burst_idx;

  // payload state
  logic [7:0]       crc_hi;
  logic [7:0]       chan_store [NUM_CHANNELS];
  kind_t            out_kind;
  logic [3:0]       out_channel;
  logic [7:0]       out_value;
  logic             out_last;

  // next values
  logic [POS_W-1:0] pos_next;
  logic [15:0]      crc_next;
  logic [15:0]      tmo_count_next;
  logic             tmo_running_next;
  logic             emit;
  kind_t            emit_kind;
  logic             good_frame;
  logic             store_we;
  logic             crc_hi_we;

  logic             in_acc;
  logic             slot_free;
  logic             burst_load;
  logic [7:0]       byte_in;
  logic [15:0]      tmo_inc;
  logic [POS_W-1:0] pos_off;
  logic [IDX_W-1:0] store_idx;
  logic [IDX_W+3:0] burst_ch_wide;

  assign byte_in   = s_axis_tdata;
  assign slot_free = !out_valid || m_axis_tready;
  assign s_axis_tready = !burst_active && slot_free;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign burst_load = burst_active && slot_free;

  assign tmo_inc   = tmo_count + 16'd1;
  assign pos_off   = pos - POS_DATA;
  assign store_idx = pos_off[IDX_W-1:0];
  assign burst_ch_wide = {4'b0000, burst_idx};

  always_comb begin
    pos_next         = pos;
    crc_next         = crc;
    tmo_count_next   = tmo_count;
    tmo_running_next = tmo_running;
    emit             = 1'b0;
    emit_kind        = KIND_CHANNEL;
    good_frame       = 1'b0;
    store_we         = 1'b0;
    crc_hi_we        = 1'b0;
    if (s_axis_tuser == OP_TICK) begin
      if (tmo_running) begin
        if (tmo_inc >= timeout_ticks) begin
          tmo_running_next = 1'b0;
          tmo_count_next   = 16'd0;
          emit             = 1'b1;
          emit_kind        = KIND_TIMEOUT;
        end else begin
          tmo_count_next = tmo_inc;
        end
      end
    end else if ((pos == POS_HDR1 && byte_in == HDR1) ||
                 (pos == POS_HDR2 && byte_in == HDR2)) begin
      pos_next = pos + POS_W'(1);
      crc_next = crc16_byte(crc, byte_in);
    end else if (pos == POS_HUNT || pos == POS_HDR1 || pos == POS_HDR2) begin
      // broken or no header: a '$' starts a new one
      if (byte_in == HDR0) begin
        pos_next = POS_HDR1;
        crc_next = crc16_byte(CRC_INIT, byte_in);
      end else begin
        pos_next = POS_HUNT;
        crc_next = CRC_INIT;
      end
    end else if (pos < POS_CRC_HI) begin
      store_we = 1'b1;
      pos_next = pos + POS_W'(1);
      crc_next = crc16_byte(crc, byte_in);
    end else if (pos == POS_CRC_HI) begin
      crc_hi_we = 1'b1;
      pos_next  = pos + POS_W'(1);
    end else begin
      pos_next = POS_HUNT;
      crc_next = CRC_INIT;
      emit     = 1'b1;
      if ({crc_hi, byte_in} == crc) begin
        good_frame       = 1'b1;
        emit_kind        = KIND_CHANNEL;
        tmo_running_next = 1'b1;
        tmo_count_next   = 16'd0;
      end else begin
        emit_kind = KIND_CRC_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      pos           <= POS_HUNT;
      crc           <= CRC_INIT;
      tmo_count     <= 16'd0;
      tmo_running   <= 1'b0;
      out_valid     <= 1'b0;
      burst_active  <= 1'b0;
      burst_idx     <= '0;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
      if (in_acc) begin
        pos         <= pos_next;
        crc         <= crc_next;
        tmo_count   <= tmo_count_next;
        tmo_running <= tmo_running_next;
      end
      if ((in_acc && emit) || burst_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (in_acc && good_frame && NUM_CHANNELS > 1) begin
        burst_active <= 1'b1;
        burst_idx    <= IDX_W'(1);
      end else if (burst_load) begin
        if (burst_idx == IDX_LAST) begin
          burst_active <= 1'b0;
        end else begin
          burst_idx <= burst_idx + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && store_we) begin
      chan_store[store_idx] <= byte_in;
    end
    if (in_acc && crc_hi_we) begin
      crc_hi <= byte_in;
    end
    if (in_acc && emit) begin
      out_kind    <= emit_kind;
      out_channel <= 4'd0;
      if (good_frame) begin
        out_value <= chan_store[0];
        out_last  <= (NUM_CHANNELS == 1);
      end else begin
        out_value <= 8'd0;
        out_last  <= 1'b1;
      end
    end else if (burst_load) begin
      out_kind    <= KIND_CHANNEL;
      out_channel <= burst_ch_wide[3:0];
      out_value   <= chan_store[burst_idx];
      out_last    <= (burst_idx == IDX_LAST);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_value, out_channel};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule
